// ===== design/pfcs_pkg.sv =====
// Shared constants, verdict codes and compare helpers for the freshness checker.
`default_nettype none
package pfcs_pkg;

  localparam int unsigned TS_W      = 64;
  localparam int unsigned NOW_W     = 63;
  localparam int unsigned PLAYER_W  = 4;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned WIN_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TS_W-1:0] SIGN_BIT = {1'b1, {(TS_W-1){1'b0}}};

  localparam logic [VERDICT_W-1:0] VERDICT_OK          = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INIT_MARKER = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD     = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_OUT_OF_ORD  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_JUST_RESET  = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_SENDER  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_GRACE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER = 2'd2;

  localparam logic [WIN_W-1:0] GRACE_RST  = 32'd1000000;
  localparam logic [WIN_W-1:0] MARGIN_RST = 32'd1000000;

  // signed a < signed b
  function automatic logic slt(input logic [TS_W-1:0] a, input logic [TS_W-1:0] b);
    return (a ^ SIGN_BIT) < (b ^ SIGN_BIT);
  endfunction

  // exact signed a + unsigned b < signed c
  function automatic logic add_lt(input logic [TS_W-1:0] a, input logic [WIN_W-1:0] b,
                                  input logic [TS_W-1:0] c);
    logic [TS_W:0] s;
    s = {1'b0, a ^ SIGN_BIT} + {{(TS_W+1-WIN_W){1'b0}}, b};
    return s < {1'b0, c ^ SIGN_BIT};
  endfunction

endpackage
`default_nettype wire

// ===== design/pfcs_mem.sv =====
// Sender time memory: one write and one registered read port, per-entry valid bits.
`default_nettype none
module pfcs_mem
  import pfcs_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clr_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [TS_W-1:0]          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [TS_W-1:0]          rdata_o
);

  logic [TS_W-1:0]  mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [TS_W-1:0]  rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ===== design/pfcs_div.sv =====
// Restoring bit-serial divider of an unsigned magnitude by a small count.
`default_nettype none
module pfcs_div
  import pfcs_pkg::*;
#(
  parameter int unsigned DW = 67,
  parameter int unsigned VW = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DW-1:0]   dividend_i,
  input  wire logic [VW-1:0]   divisor_i,
  output logic                 done_o,
  output logic      [TS_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dsr_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], fits};
      rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[TS_W-1:0];

endmodule
`default_nettype wire

// ===== design/packet_freshness_clock_sync.sv =====
// Top level: packet freshness check and local clock resync sequencer.
// Each input transfer is a restart (tuser = 1) or a received packet (tuser = 0) and yields
// exactly one output transfer. The local time is now minus the epoch. A packet is checked
// against the initial marker, the grace window, its sender's last accepted stamp (held in
// a one-port-read sender memory) and a freshly restarted clock. Sender times are cleared
// at once by a restart through per-entry valid bits. A restart goes from intake straight
// to finish; a packet passes intake, timestamp, check and finish. When a resync runs, an
// accepted packet adds a walk over the sender memory; if some sender is ahead by more
// than the margin it adds a bit-serial divide wait and a step to apply the epoch. The
// finish step stalls while the output register still holds a result that has not
// been taken.
// One item is in flight at a time; a finished result waits in the output register while
// the next item is taken.
`default_nettype none
module packet_freshness_clock_sync
  import pfcs_pkg::*;
#(
  parameter int unsigned PLAYER_COUNT = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [62:0] now, [126:63] packet_timestamp, [130:127] player, rest zero
  input  wire logic [135:0]         s_axis_tdata,
  // [0] mode
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [63:0] local_time
  output logic      [63:0]          m_axis_tdata,
  // [0] accepted, [3:1] verdict, [4] resynced
  output logic      [4:0]           m_axis_tuser,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TS_W-1:0]      cfg_data_i
);

  localparam int unsigned IDXW = $clog2(PLAYER_COUNT);
  localparam int unsigned CNTW = $clog2(PLAYER_COUNT + 1);
  localparam int unsigned SUMW = TS_W + CNTW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TS   = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_WALK = 4'd3;
  localparam logic [3:0] ST_WEND = 4'd4;
  localparam logic [3:0] ST_DIVW = 4'd5;
  localparam logic [3:0] ST_APPL = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;

  logic [3:0] state_q, state_d;

  // configuration
  logic [WIN_W-1:0] grace_q, margin_q;
  logic [TS_W-1:0]  marker_q;

  // block state
  logic [TS_W-1:0] epoch_q;
  logic [1:0]      acc_cnt_q;
  logic            pending_q;

  // per-item working registers
  logic [NOW_W-1:0]    now_q;
  logic [TS_W-1:0]     pt_q;
  logic [PLAYER_W-1:0] player_q;
  logic [TS_W-1:0]     ts_q;
  logic                acc_q;
  logic [VERDICT_W-1:0] verdict_q;
  logic                done_q;
  logic [CNTW-1:0]     wcnt_q;
  logic [SUMW-1:0]     sum_q;
  logic [CNTW-1:0]     num_q;
  logic [TS_W-1:0]     diff_q;

  // output register
  logic                 out_vld_q;
  logic [TS_W-1:0]      out_lt_q;
  logic                 out_acc_q;
  logic [VERDICT_W-1:0] out_verdict_q;
  logic                 out_done_q;

  logic in_xfer;
  logic out_free;
  logic player_ok;
  logic [IDXW-1:0] player_idx_in, player_idx_q;

  logic            mem_we, mem_re, mem_clr;
  logic [IDXW-1:0] mem_raddr;
  logic [TS_W-1:0] mem_rdata;

  logic            div_start, div_done;
  logic [TS_W-1:0] div_quot;
  logic            sum_neg;
  logic [SUMW-1:0] sum_mag;

  logic [VERDICT_W-1:0] chk_verdict;
  logic                 chk_acc;
  logic [1:0]           cnt_inc;
  logic                 walk_hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign player_idx_in = IDXW'(s_axis_tdata[130:127] - 4'd1);
  assign player_idx_q  = IDXW'(player_q - 4'd1);
  assign player_ok     = (player_q != '0) && (player_q <= PLAYER_W'(PLAYER_COUNT));

  // verdict in check order: marker, too old, bad sender, out of order, just reset
  always_comb begin
    chk_verdict = VERDICT_OK;
    chk_acc     = 1'b0;
    if (pt_q == marker_q) begin
      chk_verdict = VERDICT_INIT_MARKER;
    end else if (add_lt(pt_q, grace_q, ts_q)) begin
      chk_verdict = VERDICT_TOO_OLD;
    end else if (!player_ok) begin
      chk_verdict = VERDICT_BAD_SENDER;
    end else if (slt(pt_q, mem_rdata)) begin
      chk_verdict = VERDICT_OUT_OF_ORD;
    end else if (!pending_q && slt(ts_q, {{(TS_W-WIN_W){1'b0}}, grace_q})
                 && add_lt(ts_q, grace_q, pt_q)) begin
      chk_verdict = VERDICT_JUST_RESET;
    end else begin
      chk_acc = 1'b1;
    end
  end

  assign cnt_inc  = (acc_cnt_q == 2'd3) ? 2'd3 : acc_cnt_q + 2'd1;
  assign walk_hit = add_lt(ts_q, margin_q, mem_rdata);

  // memory ports: read the sender on intake, walk all senders during a resync
  assign mem_clr   = in_xfer && s_axis_tuser;
  assign mem_we    = (state_q == ST_CHK) && chk_acc;
  assign mem_re    = (in_xfer && !s_axis_tuser)
                  || ((state_q == ST_WALK) && (wcnt_q < CNTW'(PLAYER_COUNT)));
  assign mem_raddr = (state_q == ST_WALK) ? wcnt_q[IDXW-1:0] : player_idx_in;

  pfcs_mem #(
    .DEPTH(PLAYER_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .we_i    (mem_we),
    .waddr_i (player_idx_q),
    .wdata_i (pt_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign sum_neg   = sum_q[SUMW-1];
  assign sum_mag   = sum_neg ? SUMW'(-sum_q) : sum_q;
  assign div_start = (state_q == ST_WEND) && (num_q != '0);

  pfcs_div #(
    .DW(SUMW),
    .VW(CNTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (num_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = s_axis_tuser ? ST_FIN : ST_TS;
        end
      end
      ST_TS:   state_d = ST_CHK;
      ST_CHK: begin
        if (chk_acc && pending_q && cnt_inc[1]) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_WALK: begin
        if (wcnt_q == CNTW'(PLAYER_COUNT)) begin
          state_d = ST_WEND;
        end
      end
      ST_WEND: state_d = (num_q == '0) ? ST_FIN : ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_d = ST_APPL;
        end
      end
      ST_APPL: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q    <= s_axis_tdata[62:0];
      pt_q     <= s_axis_tdata[126:63];
      player_q <= s_axis_tdata[130:127];
    end
    if (state_q == ST_TS) begin
      ts_q <= {1'b0, now_q} - epoch_q;
    end
    if (state_q == ST_CHK) begin
      wcnt_q <= '0;
      sum_q  <= '0;
      num_q  <= '0;
    end
    if (state_q == ST_WALK) begin
      wcnt_q <= wcnt_q + 1'b1;
      // accumulate data read in the previous cycle
      if (wcnt_q != '0 && walk_hit) begin
        sum_q <= sum_q + {{CNTW{mem_rdata[TS_W-1]}}, mem_rdata};
        num_q <= num_q + 1'b1;
      end
    end
    // signed average minus local time: the amount to pull the epoch back
    if (state_q == ST_DIVW && div_done) begin
      diff_q <= (sum_neg ? -div_quot : div_quot) - ts_q;
    end
    if (state_q == ST_FIN && out_free) begin
      out_lt_q      <= {1'b0, now_q} - epoch_q;
      out_acc_q     <= acc_q;
      out_verdict_q <= verdict_q;
      out_done_q    <= done_q;
    end
  end

  // control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      grace_q   <= GRACE_RST;
      margin_q  <= MARGIN_RST;
      marker_q  <= '0;
      epoch_q   <= '0;
      acc_cnt_q <= '0;
      pending_q <= 1'b0;
      acc_q     <= 1'b0;
      verdict_q <= VERDICT_OK;
      done_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRACE:  grace_q  <= cfg_data_i[WIN_W-1:0];
          REG_MARGIN: margin_q <= cfg_data_i[WIN_W-1:0];
          REG_MARKER: marker_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer) begin
        acc_q     <= 1'b0;
        verdict_q <= VERDICT_OK;
        done_q    <= 1'b0;
        if (s_axis_tuser) begin
          epoch_q   <= {1'b0, s_axis_tdata[62:0]};
          acc_cnt_q <= '0;
        end
      end
      if (state_q == ST_CHK) begin
        acc_q     <= chk_acc;
        verdict_q <= chk_verdict;
        if (chk_verdict == VERDICT_JUST_RESET) begin
          pending_q <= 1'b1;
        end
        if (chk_acc) begin
          acc_cnt_q <= cnt_inc;
        end
      end
      if (state_q == ST_APPL) begin
        epoch_q   <= epoch_q - diff_q;
        pending_q <= 1'b0;
        done_q    <= 1'b1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_lt_q;
  assign m_axis_tuser  = {out_done_q, out_verdict_q, out_acc_q};

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the packet freshness checker and clock resync block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pfcs_pkg::*;

  localparam int unsigned SENDERS = 4;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_ITEMS = 1850;

  // One input transfer: restart or received packet.
  typedef struct packed {
    logic             restart;
    logic [NOW_W-1:0] now;
    logic [TS_W-1:0]  stamp;
    logic [PLAYER_W-1:0] player;
  } stamp_item_t;

  // One output transfer.
  typedef struct packed {
    logic                 accepted;
    logic [VERDICT_W-1:0] verdict;
    logic                 resynced;
    logic [TS_W-1:0]      local_time;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_GRACE;
  logic [TS_W-1:0] cfg_data_i = '0;

  packet_freshness_clock_sync #(.PLAYER_COUNT(SENDERS)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and state.
  logic [WIN_W-1:0] grace_q = GRACE_RST;
  logic [WIN_W-1:0] margin_q = MARGIN_RST;
  logic [TS_W-1:0]  marker_q = '0;
  logic [TS_W-1:0]  epoch_q = '0;
  logic [TS_W-1:0]  last_stamp_q [SENDERS];
  int unsigned      accept_cnt_q = 0;
  logic             resync_pend_q = 1'b0;

  stamp_item_t pending_items[$];
  verdict_t    expected_verdicts[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Exact signed a + unsigned b < signed c, no wrap.
  function automatic logic lead_below(input logic [TS_W-1:0] a, input logic [WIN_W-1:0] b,
                                      input logic [TS_W-1:0] c);
    logic signed [TS_W+1:0] lhs;
    logic signed [TS_W+1:0] rhs;
    lhs = $signed({a[TS_W-1], a[TS_W-1], a}) + $signed({34'b0, b});
    rhs = $signed({c[TS_W-1], c[TS_W-1], c});
    return lhs < rhs;
  endfunction

  // Advance the shadow state by one accepted item and queue its verdict.
  task automatic predict_verdict(input stamp_item_t it);
    verdict_t v;
    logic [TS_W-1:0] lt;
    logic signed [127:0] sum;
    logic signed [127:0] quot;
    int unsigned idx;
    int unsigned num;
    v = '0;
    if (it.restart) begin
      epoch_q = {1'b0, it.now};
      foreach (last_stamp_q[i]) last_stamp_q[i] = '0;
      accept_cnt_q = 0;
    end else begin
      lt = {1'b0, it.now} - epoch_q;
      idx = it.player - 1;
      if (it.stamp == marker_q) begin
        v.verdict = VERDICT_INIT_MARKER;
      end else if (lead_below(it.stamp, grace_q, lt)) begin
        v.verdict = VERDICT_TOO_OLD;
      end else if (it.player == 0 || it.player > SENDERS) begin
        v.verdict = VERDICT_BAD_SENDER;
      end else if ($signed(it.stamp) < $signed(last_stamp_q[idx])) begin
        v.verdict = VERDICT_OUT_OF_ORD;
      end else if (!resync_pend_q && $signed(lt) < $signed({32'b0, grace_q}) &&
                   lead_below(lt, grace_q, it.stamp)) begin
        resync_pend_q = 1'b1;
        v.verdict = VERDICT_JUST_RESET;
      end else begin
        v.verdict = VERDICT_OK;
        v.accepted = 1'b1;
        last_stamp_q[idx] = it.stamp;
        if (accept_cnt_q < 3) accept_cnt_q++;
        if (resync_pend_q && accept_cnt_q >= 2) begin
          // average the senders that lead by more than the margin
          sum = '0;
          num = 0;
          foreach (last_stamp_q[i]) begin
            if (lead_below(lt, margin_q, last_stamp_q[i])) begin
              sum += $signed({{64{last_stamp_q[i][63]}}, last_stamp_q[i]});
              num++;
            end
          end
          if (num != 0) begin
            quot = sum / $signed({96'b0, num});
            epoch_q = epoch_q - (quot[63:0] - lt);
            resync_pend_q = 1'b0;
            v.resynced = 1'b1;
          end
        end
      end
    end
    v.local_time = {1'b0, it.now} - epoch_q;
    expected_verdicts.push_back(v);
  endtask

  // Driver: present queued items, random gap after each transfer.
  int unsigned in_gap = 0;
  logic in_calm = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    stamp_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_verdict({s_axis_tuser, s_axis_tdata[62:0], s_axis_tdata[126:63],
                         s_axis_tdata[130:127]});
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 11);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap == 0 && pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          s_axis_tdata <= {5'b0, nxt.player, nxt.stamp, nxt.now};
          s_axis_tuser <= nxt.restart;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (in_gap != 0) in_gap--;
        end
      end
    end
  end

  // Monitor: random stall before each result, compare against the oldest expectation.
  int unsigned out_stall = 0;
  logic out_calm = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tuser[3:1], m_axis_tuser[4], m_axis_tdata};
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected acc=%0d verdict=%0d resync=%0d time=%0d",
                       want.accepted, want.verdict, want.resynced, $signed(want.local_time));
              $display("  got acc=%0d verdict=%0d resync=%0d time=%0d",
                       got.accepted, got.verdict, got.resynced, $signed(got.local_time));
            end
          end
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 11);
      end else if (out_stall != 0) begin
        out_stall--;
      end
      m_axis_tready <= (out_stall == 0);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus generator's own guess of the local clock.
  logic [62:0] gen_now;
  logic [63:0] gen_epoch;
  logic [63:0] gen_last [SENDERS];

  task automatic add_item(input logic rs, input logic [62:0] n, input logic [63:0] st,
                          input logic [3:0] pl);
    pending_items.push_back('{restart: rs, now: n, stamp: st, player: pl});
    if (rs) begin
      gen_epoch = {1'b0, n};
      foreach (gen_last[i]) gen_last[i] = '0;
    end else if (pl >= 1 && pl <= SENDERS) begin
      if ($signed(st) > $signed(gen_last[pl-1])) gen_last[pl-1] = st;
    end
  endtask

  task automatic add_random_item();
    logic [63:0] lt;
    logic [63:0] st;
    logic [3:0] pl;
    logic [63:0] span;
    int unsigned kind;
    span = {32'b0, grace_q} + 64'd1;
    gen_now = gen_now
            + 63'($urandom_range(0, 3000) * ($urandom_range(0, 3) == 0 ? 400 : 1));
    pl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
    lt = {1'b0, gen_now} - gen_epoch;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      gen_now = gen_now + 63'($urandom_range(0, 500000));
      add_item(1'b1, gen_now, {$urandom, $urandom}, pl);
      return;
    end else if (kind < 9) begin
      st = marker_q;
    end else if (kind < 14) begin
      st = lt - span - {32'b0, $urandom};
    end else if (kind < 24) begin
      // far ahead of the local clock
      st = lt + span + {32'b0, margin_q} + {32'b0, $urandom};
    end else if (kind < 30) begin
      st = gen_last[($urandom_range(1, 4)) - 1] - $urandom_range(1, 50);
    end else if (kind < 36) begin
      st = {$urandom, $urandom};
      if ($urandom_range(0, 1)) gen_now = 63'({$urandom, $urandom});
    end else begin
      st = lt + {32'b0, $urandom} % span - ({32'b0, $urandom} % span) / 2;
    end
    add_item(1'b0, gen_now, st, pl);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRACE:  grace_q = val[WIN_W-1:0];
      REG_MARGIN: margin_q = val[WIN_W-1:0];
      default:    marker_q = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned per_phase;
    foreach (last_stamp_q[i]) last_stamp_q[i] = '0;
    foreach (gen_last[i]) gen_last[i] = '0;
    gen_epoch = '0;
    gen_now = 63'd5000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: marker, bad senders, too old, out of order, just reset, resync, extremes.
    add_item(1'b0, 63'd0, 64'd0, 4'd1);
    add_item(1'b0, 63'd10, 64'd5, 4'd0);
    add_item(1'b0, 63'd10, 64'd5, 4'd15);
    add_item(1'b1, 63'd1000, 64'd0, 4'd1);
    add_item(1'b0, 63'd1100, 64'd5000000, 4'd1);
    add_item(1'b0, 63'd1200, 64'd3000000, 4'd2);
    add_item(1'b0, 63'd1300, 64'd4000000, 4'd3);
    add_item(1'b0, 63'd1400, 64'd90, 4'd2);
    add_item(1'b0, 63'd1500, 64'd6000000, 4'd4);
    add_item(1'b0, 63'h7fffffffffffffff, 64'h7fffffffffffffff, 4'd4);
    add_item(1'b0, 63'h7fffffffffffffff, 64'h8000000000000000, 4'd1);
    add_item(1'b0, 63'h7fffffffffffffff, 64'hffffffffffffffff, 4'd5);
    add_item(1'b1, 63'h7fffffffffffffff, 64'h0, 4'd0);
    add_item(1'b0, 63'h0, 64'h8000000000000000, 4'd3);
    add_item(1'b0, 63'h0, 64'h7fffffffffffffff, 4'd3);
    add_item(1'b1, 63'd0, 64'd0, 4'd0);
    add_item(1'b0, 63'd2000, 64'hfffffffffff00000, 4'd2);
    add_item(1'b0, 63'd2100, 64'd1, 4'd1);
    add_item(1'b0, 63'd2200, 64'd1, 4'd1);
    add_item(1'b0, 63'd2300, 64'd0, 4'd1);
    drain();

    // Random phases, each under its own register setting.
    per_phase = RANDOM_ITEMS / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_GRACE, 64'd0);
          write_reg(REG_MARGIN, 64'd0);
          write_reg(REG_MARKER, 64'hffffffffffffffff);
        end
        2: begin
          write_reg(REG_GRACE, 64'hffffffff);
          write_reg(REG_MARGIN, 64'hffffffff);
          write_reg(REG_MARKER, 64'h8000000000000000);
        end
        3: begin
          write_reg(REG_GRACE, 64'd1000);
          write_reg(REG_MARGIN, 64'd200);
          write_reg(REG_MARKER, 64'h7fffffffffffffff);
        end
        4, 5, 6: begin
          write_reg(REG_GRACE, {$urandom, 32'($urandom_range(0, 3000000))});
          write_reg(REG_MARGIN, {$urandom, 32'($urandom_range(0, 3000000))});
          write_reg(REG_MARKER, {$urandom, $urandom});
        end
        7: begin
          write_reg(REG_GRACE, 64'd1000000);
          write_reg(REG_MARGIN, 64'd1000000);
          write_reg(REG_MARKER, 64'd0);
        end
        default: ;
      endcase
      for (int k = 0; k < per_phase; k++) add_random_item();
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
